// ===== rtl/bve_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bve_pkg: shared types and constants of the bounded vector engine
// Widths, action and status codes, controller states, and the command and
// status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package bve_pkg;

    localparam int IDX_W    = 10;
    localparam int CNT_W    = IDX_W + 1;
    localparam int DATA_W   = 32;
    localparam int CAPACITY = 1 << IDX_W;

    typedef enum logic [2:0] {
        ACT_PUSH    = 3'd0,
        ACT_POP     = 3'd1,
        ACT_INSERT  = 3'd2,
        ACT_REMOVE  = 3'd3,
        ACT_READ    = 3'd4,
        ACT_REVERSE = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_PUT,
        S_REV_A,
        S_REV_B,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic decode;
        logic shift;
        logic put;
        logic rev_a;
        logic rev_b;
        logic finish;
    } bve_cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t act;
        logic    ok;
        logic    cnt_lt2;
        logic    shift_busy;
        logic    rev_more;
        logic    out_free;
    } bve_stat_t;

endpackage
`default_nettype wire

// ===== rtl/bve_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bve_ctrl: sequencing state machine
// Takes one request at a time, steps the datapath through decode, the
// memory walk of insert, remove or reverse, and hands off the result.
// ----------------------------------------------------------------------------
module bve_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bve_pkg::bve_stat_t  stat,
    output bve_pkg::bve_cmd_t   cmd
);
    import bve_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (!stat.ok)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    case (stat.act)
                        ACT_INSERT,
                        ACT_REMOVE:  state_next = S_SHIFT;
                        ACT_REVERSE: state_next = stat.cnt_lt2 ? S_DONE : S_REV_A;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_busy)
                begin
                    cmd.shift = 1'b1;
                end
                else if (stat.act == ACT_INSERT)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_DONE;
            end
            S_REV_A:
            begin
                cmd.rev_a  = 1'b1;
                state_next = S_REV_B;
            end
            S_REV_B:
            begin
                cmd.rev_b  = 1'b1;
                state_next = stat.rev_more ? S_REV_A : S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/bve_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bve_datapath: entry memory, count, walk pointers and result register
// Checks each request against the count, moves entries through one read
// and one write port, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module bve_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [2:0]                        action,
    input  logic [bve_pkg::IDX_W-1:0]         index,
    input  logic signed [bve_pkg::DATA_W-1:0] item,
    input  bve_pkg::bve_cmd_t                 cmd,
    output bve_pkg::bve_stat_t                stat,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic signed [bve_pkg::DATA_W-1:0] read_value,
    output logic [1:0]                        status,
    output logic [bve_pkg::CNT_W-1:0]         count_now,
    output logic                              is_empty,
    output logic                              is_full
);
    import bve_pkg::*;

    // request
    action_t              act_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [DATA_W-1:0]    item_reg;
    status_t              status_reg;
    status_t              code;

    // list state
    logic [DATA_W-1:0]    entries_mem [CAPACITY];
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;

    // walk state
    logic [IDX_W-1:0]     ptr_a_reg, ptr_a_next;
    logic [IDX_W-1:0]     ptr_b_reg, ptr_b_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic                 wpend_reg, wpend_next;
    logic [DATA_W-1:0]    hold_reg, hold_next;
    logic [DATA_W-1:0]    rdata_reg;

    // memory port
    logic                 mem_re;
    logic                 mem_we;
    logic [IDX_W-1:0]     raddr;
    logic [IDX_W-1:0]     waddr;
    logic [DATA_W-1:0]    wdata;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    read_value_reg;
    status_t              status_out_reg;
    logic [CNT_W-1:0]     count_now_reg;
    logic                 empty_reg;
    logic                 full_reg;

    logic [CNT_W-1:0]     idx_ext;
    logic                 list_full;
    logic                 list_empty;
    logic                 step_up;
    logic                 rev_more;

    assign idx_ext    = {1'b0, idx_reg};
    assign list_full  = (cnt_reg == CNT_W'(CAPACITY));
    assign list_empty = (cnt_reg == '0);
    assign step_up    = (act_reg == ACT_REMOVE);
    assign rev_more   = (ptr_a_reg < ptr_b_reg);

    // request check against the current count
    always_comb
    begin
        code = ST_OK;
        case (act_reg)
            ACT_PUSH:
            begin
                if (list_full)
                    code = ST_FULL;
            end
            ACT_POP:
            begin
                if (list_empty)
                    code = ST_EMPTY;
            end
            ACT_INSERT:
            begin
                if (idx_ext > cnt_reg)
                    code = ST_RANGE;
                else if (list_full)
                    code = ST_FULL;
            end
            ACT_REMOVE,
            ACT_READ:
            begin
                if (list_empty)
                    code = ST_EMPTY;
                else if (idx_ext >= cnt_reg)
                    code = ST_RANGE;
            end
            default:
            begin
                code = ST_OK;
            end
        endcase
    end

    // count after the request
    always_comb
    begin
        cnt_next = cnt_reg;
        if (status_reg == ST_OK)
        begin
            case (act_reg)
                ACT_PUSH,
                ACT_INSERT: cnt_next = cnt_reg + 1'b1;
                ACT_POP,
                ACT_REMOVE: cnt_next = cnt_reg - 1'b1;
                default:    cnt_next = cnt_reg;
            endcase
        end
    end

    // walk control and memory port selection
    always_comb
    begin
        ptr_a_next = ptr_a_reg;
        ptr_b_next = ptr_b_reg;
        left_next  = left_reg;
        wpend_next = wpend_reg;
        hold_next  = hold_reg;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        raddr      = ptr_a_reg;
        waddr      = ptr_b_reg;
        wdata      = rdata_reg;

        if (cmd.decode)
        begin
            wpend_next = 1'b0;
            case (act_reg)
                ACT_PUSH:
                begin
                    if (code == ST_OK)
                    begin
                        mem_we = 1'b1;
                        waddr  = cnt_reg[IDX_W-1:0];
                        wdata  = item_reg;
                    end
                end
                ACT_INSERT:
                begin
                    // walk down from the last entry, each moves up one place
                    ptr_a_next = IDX_W'(cnt_reg - 1'b1);
                    ptr_b_next = cnt_reg[IDX_W-1:0];
                    left_next  = cnt_reg - idx_ext;
                end
                ACT_REMOVE:
                begin
                    // walk up from the entry after the hole
                    ptr_a_next = idx_reg + 1'b1;
                    ptr_b_next = idx_reg;
                    left_next  = cnt_reg - idx_ext - 1'b1;
                end
                ACT_READ:
                begin
                    if (code == ST_OK)
                    begin
                        mem_re = 1'b1;
                        raddr  = idx_reg;
                    end
                end
                ACT_REVERSE:
                begin
                    ptr_a_next = '0;
                    ptr_b_next = IDX_W'(cnt_reg - 1'b1);
                end
                default:
                begin
                    wpend_next = 1'b0;
                end
            endcase
        end

        // shift: read one entry ahead, write the previous read behind it
        if (cmd.shift)
        begin
            if (left_reg != '0)
            begin
                mem_re     = 1'b1;
                raddr      = ptr_a_reg;
                ptr_a_next = step_up ? ptr_a_reg + 1'b1 : ptr_a_reg - 1'b1;
                left_next  = left_reg - 1'b1;
            end
            if (wpend_reg)
            begin
                mem_we     = 1'b1;
                waddr      = ptr_b_reg;
                wdata      = rdata_reg;
                ptr_b_next = step_up ? ptr_b_reg + 1'b1 : ptr_b_reg - 1'b1;
            end
            wpend_next = (left_reg != '0);
        end

        // new value into the opened slot
        if (cmd.put)
        begin
            mem_we = 1'b1;
            waddr  = idx_reg;
            wdata  = item_reg;
        end

        // reverse, low half: read low entry, write previous pair's low slot
        if (cmd.rev_a)
        begin
            if (rev_more)
            begin
                mem_re = 1'b1;
                raddr  = ptr_a_reg;
            end
            if (wpend_reg)
            begin
                mem_we = 1'b1;
                waddr  = ptr_a_reg - 1'b1;
                wdata  = rdata_reg;
            end
        end

        // reverse, high half: read high entry, write previous pair's high slot
        if (cmd.rev_b)
        begin
            if (rev_more)
            begin
                mem_re     = 1'b1;
                raddr      = ptr_b_reg;
                hold_next  = rdata_reg;
                ptr_a_next = ptr_a_reg + 1'b1;
                ptr_b_next = ptr_b_reg - 1'b1;
            end
            if (wpend_reg)
            begin
                mem_we = 1'b1;
                waddr  = ptr_b_reg + 1'b1;
                wdata  = hold_reg;
            end
            wpend_next = rev_more;
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ptr_a_reg     <= '0;
            ptr_b_reg     <= '0;
            left_reg      <= '0;
            wpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
                cnt_reg <= cnt_next;
            ptr_a_reg     <= ptr_a_next;
            ptr_b_reg     <= ptr_b_next;
            left_reg      <= left_next;
            wpend_reg     <= wpend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action_t'(action);
            idx_reg  <= index;
            item_reg <= item;
        end
        if (cmd.decode)
            status_reg <= code;
        hold_reg <= hold_next;
        if (cmd.finish)
        begin
            read_value_reg <= (act_reg == ACT_READ && status_reg == ST_OK) ? rdata_reg : '0;
            status_out_reg <= status_reg;
            count_now_reg  <= cnt_next;
            empty_reg      <= (cnt_next == '0);
            full_reg       <= (cnt_next == CNT_W'(CAPACITY));
        end
    end

    // entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entries_mem[waddr] <= wdata;
        if (mem_re)
            rdata_reg <= entries_mem[raddr];
    end

    // status to the controller
    always_comb
    begin
        stat.act        = act_reg;
        stat.ok         = (code == ST_OK);
        stat.cnt_lt2    = (cnt_reg < CNT_W'(2));
        stat.shift_busy = (left_reg != '0) || wpend_reg;
        stat.rev_more   = rev_more;
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_out_reg;
    assign count_now  = count_now_reg;
    assign is_empty   = empty_reg;
    assign is_full    = full_reg;

`ifndef SYNTHESIS
    // count never passes capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // the walk never reads an entry in the cycle it is overwritten
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (waddr != raddr))
        else $error("memory read and write at the same address");

    // a result is only loaded into a free output register
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote an untaken result");

    // the count moves only when a request completes
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.finish |=> $stable(cnt_reg))
        else $error("entry count changed mid request");
`endif

endmodule
`default_nettype wire

// ===== rtl/bounded_vector_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_vector_engine: ordered list of up to 1024 signed 32-bit values
// Push, pop, insert, remove, read and reverse, one result per request.
// ----------------------------------------------------------------------------
// One request is handled at a time; every request gives exactly one result
// with read data, status, the new count and empty/full flags. Insert and
// remove move the entries behind the index one by one through the single
// read/write memory port pair; reverse swaps entries pair by pair through
// the same ports, and a list of fewer than two entries is left as it is.
// A new request is accepted while the previous result still waits in the
// output register.
module bounded_vector_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        action,
    input  logic [bve_pkg::IDX_W-1:0]         index,
    input  logic signed [bve_pkg::DATA_W-1:0] item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bve_pkg::DATA_W-1:0] read_value,
    output logic [1:0]                        status,
    output logic [bve_pkg::CNT_W-1:0]         count_now,
    output logic                              is_empty,
    output logic                              is_full
);
    import bve_pkg::*;

    bve_cmd_t  cmd;
    bve_stat_t stat;

    // sequencing
    bve_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and result
    bve_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .action     (action),
        .index      (index),
        .item       (item),
        .cmd        (cmd),
        .stat       (stat),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .read_value (read_value),
        .status     (status),
        .count_now  (count_now),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

endmodule
`default_nettype wire

// ===== tb/sv/bounded_vector_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_vector_engine_test: self-checking bench for the bounded vector engine
// Drives push, pop, insert, remove, read and reverse requests through the
// valid/stall handshake. A behavioral list model predicts each result that
// the table does not give by hand, and each result is compared field by
// field with the oldest expected one. A short table covers the empty,
// one-entry and full corner cases. The list is then filled to capacity and
// drained, and random traffic follows under three idle/stall mixes.
// ----------------------------------------------------------------------------
module bounded_vector_engine_test;
    import bve_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int          RESET_CYCLES = 10;
    localparam int          PHASE_ITEMS  = 194;
    localparam int          DRAIN_FLOOR  = 16;
    localparam int          CYCLE_LIMIT  = 20_000_000;
    localparam int          FULL_ROWS_AT = 19;
    localparam logic [2:0]  ACT_SPARE_6  = 3'd6;
    localparam logic [2:0]  ACT_SPARE_7  = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        status_t                  status;
        logic [CNT_W-1:0]         count_now;
        logic                     is_empty;
        logic                     is_full;
    } list_result_t;

    typedef struct packed {
        logic [2:0]               act;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        logic                     known;
        list_result_t             want;
    } stim_row_t;

    // dut ports
    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic [2:0]               action     = '0;
    logic [IDX_W-1:0]         index      = '0;
    logic signed [DATA_W-1:0] item       = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count_now;
    logic                     is_empty;
    logic                     is_full;

    // list model state
    logic signed [DATA_W-1:0] list_mem [0:CAPACITY-1];
    int                       list_count = 0;

    list_result_t             pending_results [$];
    list_result_t             oldest;
    stim_row_t                stim_table [$];

    int send_idle_pct  = 8;
    int recv_stall_pct = 57;
    int err_count      = 0;
    int results_seen   = 0;
    int peak_count     = 0;
    int cycle_count    = 0;
    int act_seen [8];

    bounded_vector_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .index      (index),
        .item       (item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status),
        .count_now  (count_now),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // run-time guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached, %0d results outstanding", $time,
                     pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // list model: applies one request and returns the result it gives
    function automatic list_result_t apply_request(input logic [2:0] act,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic signed [DATA_W-1:0] val);
        list_result_t             r;
        int                       pos;
        int                       i;
        logic signed [DATA_W-1:0] swap;
        pos          = int'(idx);
        r.read_value = '0;
        r.status     = ST_OK;
        case (act)
            ACT_PUSH:
            begin
                if (list_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_mem[list_count] = val;
                    list_count++;
                end
            end
            ACT_POP:
            begin
                if (list_count == 0)
                    r.status = ST_EMPTY;
                else
                    list_count--;
            end
            ACT_INSERT:
            begin
                // index test comes before the full test
                if (pos > list_count)
                    r.status = ST_RANGE;
                else if (list_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_count; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = val;
                    list_count++;
                end
            end
            ACT_REMOVE:
            begin
                if (list_count == 0)
                    r.status = ST_EMPTY;
                else if (pos >= list_count)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = pos; i + 1 < list_count; i++)
                        list_mem[i] = list_mem[i+1];
                    list_count--;
                end
            end
            ACT_READ:
            begin
                if (list_count == 0)
                    r.status = ST_EMPTY;
                else if (pos >= list_count)
                    r.status = ST_RANGE;
                else
                    r.read_value = list_mem[pos];
            end
            ACT_REVERSE:
            begin
                for (i = 0; i < list_count / 2; i++)
                begin
                    swap                       = list_mem[i];
                    list_mem[i]                = list_mem[list_count-1-i];
                    list_mem[list_count-1-i]   = swap;
                end
            end
            default:
            begin
                // spare action codes leave the list alone
            end
        endcase
        r.count_now = CNT_W'(list_count);
        r.is_empty  = (list_count == 0);
        r.is_full   = (list_count == CAPACITY);
        return r;
    endfunction

    // table rows: with a hand-written result, or left to the list model
    function automatic stim_row_t known_row(input logic [2:0] act, input int idx,
                                            input logic signed [DATA_W-1:0] val,
                                            input logic signed [DATA_W-1:0] rd,
                                            input status_t st, input int cnt);
        stim_row_t row;
        row.act             = act;
        row.idx             = IDX_W'(idx);
        row.val             = val;
        row.known           = 1'b1;
        row.want.read_value = rd;
        row.want.status     = st;
        row.want.count_now  = CNT_W'(cnt);
        row.want.is_empty   = (cnt == 0);
        row.want.is_full    = (cnt == CAPACITY);
        return row;
    endfunction

    function automatic stim_row_t model_row(input logic [2:0] act, input int idx,
                                            input logic signed [DATA_W-1:0] val);
        stim_row_t row;
        row       = known_row(act, idx, val, '0, ST_OK, 0);
        row.known = 1'b0;
        return row;
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // uniform index in 0..hi, clipped to the index width
    function automatic logic [IDX_W-1:0] pick_index(input int hi);
        int top;
        top = (hi > CAPACITY - 1) ? CAPACITY - 1 : (hi < 0 ? 0 : hi);
        return IDX_W'($urandom_range(0, top));
    endfunction

    // offer one request, wait for the handshake, log its expected result
    task automatic send_request(input logic [2:0] act, input logic [IDX_W-1:0] idx,
                                input logic signed [DATA_W-1:0] val,
                                input logic known, input list_result_t want);
        list_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        action   = act;
        index    = idx;
        item     = val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_request(act, idx, val);
        pending_results.push_back(known ? want : predicted);
        act_seen[act]++;
        if (list_count > peak_count)
            peak_count = list_count;
        @(negedge clk);
    endtask

    // hold off until every outstanding result is back
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // mostly pushes, with some inserts and reads, until the list is full
    task automatic fill_list();
        int r;
        while (list_count < CAPACITY)
        begin
            r = $urandom_range(0, 99);
            if (r < 85 || list_count == 0)
                send_request(ACT_PUSH, IDX_W'($urandom), random_value(), 1'b0, '0);
            else if (r < 92)
                send_request(ACT_INSERT, pick_index(list_count), random_value(), 1'b0, '0);
            else
                send_request(ACT_READ, pick_index(list_count - 1), random_value(), 1'b0, '0);
        end
    endtask

    // mostly pops, with some removes and reads, down to a short list
    task automatic drain_list();
        int r;
        while (list_count > DRAIN_FLOOR)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                send_request(ACT_POP, IDX_W'($urandom), random_value(), 1'b0, '0);
            else if (r < 90)
                send_request(ACT_REMOVE, pick_index(list_count - 1), random_value(), 1'b0, '0);
            else
                send_request(ACT_READ, pick_index(list_count - 1), random_value(), 1'b0, '0);
        end
    endtask

    // random request; the mix leans toward growth on a short list
    task automatic random_request();
        logic [2:0]       act;
        logic [IDX_W-1:0] idx;
        logic             grow;
        int               r;
        grow = (list_count < 96);
        r    = $urandom_range(0, 99);
        if (r < 2)
            act = 3'($urandom_range(ACT_SPARE_6, ACT_SPARE_7));
        else if (r < 10)
            act = ACT_REVERSE;
        else if (r < 30)
            act = ACT_READ;
        else if (r < (grow ? 55 : 40))
            act = ACT_PUSH;
        else if (r < (grow ? 72 : 62))
            act = ACT_INSERT;
        else if (r < 85)
            act = ACT_POP;
        else
            act = ACT_REMOVE;
        // half near the valid range, half anywhere in the index field
        if ($urandom_range(0, 1))
            idx = pick_index(list_count);
        else
            idx = IDX_W'($urandom);
        send_request(act, idx, random_value(), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want_v,
                               input logic [DATA_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     want_v, got_v);
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: result with none expected, expected nothing, %s %0h/%0d/%0d",
                         $time, "actual", read_value, status, count_now);
            end
            else
            begin
                oldest = pending_results[0];
                pending_results.delete(0);
                results_seen++;
                check_field("read_value", oldest.read_value, read_value);
                check_field("status", DATA_W'(oldest.status), DATA_W'(status));
                check_field("count_now", DATA_W'(oldest.count_now), DATA_W'(count_now));
                check_field("is_empty", DATA_W'(oldest.is_empty), DATA_W'(is_empty));
                check_field("is_full", DATA_W'(oldest.is_full), DATA_W'(is_full));
            end
        end
    end

    // stimulus
    initial
    begin
        int        k;
        int        phase;
        stim_row_t row;

        // empty list, then short lists of one to four entries
        stim_table.push_back(known_row(ACT_POP,     0,    0, 0, ST_EMPTY, 0));
        stim_table.push_back(known_row(ACT_READ,    0,    0, 0, ST_EMPTY, 0));
        stim_table.push_back(known_row(ACT_REMOVE,  0,    0, 0, ST_EMPTY, 0));
        stim_table.push_back(known_row(ACT_REVERSE, 0,    0, 0, ST_OK,    0));
        stim_table.push_back(known_row(ACT_INSERT,  1,    5, 0, ST_RANGE, 0));
        stim_table.push_back(known_row(ACT_INSERT,  0, 32'sh7FFF_FFFF, 0, ST_OK, 1));
        stim_table.push_back(known_row(ACT_READ,    0, 0, 32'sh7FFF_FFFF, ST_OK, 1));
        stim_table.push_back(known_row(ACT_PUSH,    0, 32'sh8000_0000, 0, ST_OK, 2));
        stim_table.push_back(known_row(ACT_READ,    1, 0, 32'sh8000_0000, ST_OK, 2));
        stim_table.push_back(known_row(ACT_READ,    1023, 0, 0, ST_RANGE, 2));
        stim_table.push_back(known_row(ACT_REMOVE,  2,    0, 0, ST_RANGE, 2));
        stim_table.push_back(known_row(ACT_INSERT,  3,    7, 0, ST_RANGE, 2));
        stim_table.push_back(known_row(ACT_INSERT,  2,    0, 0, ST_OK,    3));
        stim_table.push_back(model_row(ACT_INSERT,  1,   -1));
        stim_table.push_back(known_row(ACT_SPARE_6, 1023, -1, 0, ST_OK,   4));
        stim_table.push_back(known_row(ACT_SPARE_7, 0,    0, 0, ST_OK,    4));
        stim_table.push_back(model_row(ACT_REVERSE, 0,    0));
        stim_table.push_back(model_row(ACT_REMOVE,  1,    0));
        stim_table.push_back(model_row(ACT_POP,     0,    0));
        // full list, filled just before these rows
        stim_table.push_back(known_row(ACT_PUSH,    0,   9, 0, ST_FULL, CAPACITY));
        stim_table.push_back(known_row(ACT_INSERT,  0,   9, 0, ST_FULL, CAPACITY));
        stim_table.push_back(known_row(ACT_INSERT,  1023, 9, 0, ST_FULL, CAPACITY));
        stim_table.push_back(model_row(ACT_READ,    1023, 0));
        stim_table.push_back(model_row(ACT_REVERSE, 0,    0));
        stim_table.push_back(model_row(ACT_REMOVE,  0,    0));
        stim_table.push_back(model_row(ACT_INSERT,  1023, 32'sh5A5A_5A5A));
        stim_table.push_back(model_row(ACT_READ,    1023, 0));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table, with the fill ahead of the full-list rows
        for (k = 0; k < stim_table.size(); k++)
        begin
            if (k == FULL_ROWS_AT)
                fill_list();
            row = stim_table[k];
            send_request(row.act, row.idx, row.val, row.known, row.want);
        end
        drain_list();

        // random traffic under three idle/stall mixes
        for (phase = 0; phase < 3; phase++)
        begin
            wait_drained();
            send_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 57 : 0;
            recv_stall_pct = (phase == 0) ? 57 : (phase == 1) ? 8 : 0;
            for (k = 0; k < PHASE_ITEMS; k++)
                random_request();
        end

        // let the last results come back, then allow for stragglers
        wait_drained();
        repeat (2 * CAPACITY + 8) @(negedge clk);

        $display("covered %0d requests: push %0d, pop %0d, insert %0d, remove %0d, read %0d,",
                 act_seen.sum(), act_seen[ACT_PUSH], act_seen[ACT_POP], act_seen[ACT_INSERT],
                 act_seen[ACT_REMOVE], act_seen[ACT_READ]);
        $display("reverse %0d, spare codes %0d; %0d results checked, list peaked at %0d entries",
                 act_seen[ACT_REVERSE], act_seen[ACT_SPARE_6] + act_seen[ACT_SPARE_7],
                 results_seen, peak_count);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
